@@ src/nnt_pkg.sv @@
// nnt_pkg: shared constants, state encoding and control structs for the
// nearest neighbor tour builder; used by nnt_scan and tsp_nearest_neighbor_tour
package nnt_pkg;

  localparam int MAX_CITIES_DEF = 32;
  localparam int DIST_WIDTH_DEF = 16;
  localparam int RESULT_CAP     = 32;

  localparam int CITY_W = 5;   // city fields on the ports
  localparam int DIN_W  = 16;  // distance field on the input port
  localparam int CFG_W  = 6;   // city_count register
  localparam int LEN_W  = 21;  // tour length

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [CFG_W-1:0] MIN_CITIES = CFG_W'(2);

  // widest city index and count over the allowed parameter range
  localparam int CITY_W_MAX = 6;
  localparam int CNT_W_MAX  = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_RET_RD,
    ST_RET_WAIT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [CITY_W_MAX-1:0] row;
    logic [CNT_W_MAX-1:0]  count;
  } scan_req_t;

  typedef struct packed {
    logic                  done;
    logic [CITY_W_MAX-1:0] best;
  } scan_res_t;

endpackage

@@ src/nnt_ram.sv @@
// nnt_ram: generic single write port, single read port ram with registered read
// no dependencies
module nnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/nnt_scan.sv @@
// nnt_scan: walks one matrix row through the ram read port and keeps the
// nearest unvisited city; depends on nnt_pkg
module nnt_scan #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int DIST_WIDTH = nnt_pkg::DIST_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  nnt_pkg::scan_req_t                           req,
  input  logic [MAX_CITIES-1:0]                        visited,
  input  logic [DIST_WIDTH-1:0]                        rd_data,
  output logic                                         rd_en,
  output logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]     rd_addr,
  output nnt_pkg::scan_res_t                           res,
  output logic [DIST_WIDTH-1:0]                        best_dist
);

  localparam int N_LIM = (MAX_CITIES < nnt_pkg::RESULT_CAP) ? MAX_CITIES
                                                              : nnt_pkg::RESULT_CAP;
  localparam int NW = $clog2(N_LIM + 1);
  localparam int IW = $clog2(MAX_CITIES);
  localparam int AW = $clog2(MAX_CITIES * MAX_CITIES);

  logic          busy_r, busy_nxt;
  logic [NW-1:0] iss_r, iss_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] row_r, row_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [DIST_WIDTH-1:0] bd_r, bd_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    busy_nxt    = busy_r;
    iss_nxt     = iss_r;
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    bd_nxt      = bd_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    done_nxt    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = AW'(32'(row_r) * 32'(MAX_CITIES) + 32'(iss_r));

    if (req.start) begin
      busy_nxt  = 1'b1;
      iss_nxt   = '0;
      cnt_nxt   = NW'(req.count);
      row_nxt   = IW'(req.row);
      found_nxt = 1'b0;
    end else if (busy_r) begin
      // one read per cycle, the compare lands in the next cycle
      rd_en       = 1'b1;
      chk_vld_nxt = 1'b1;
      chk_idx_nxt = IW'(iss_r);
      iss_nxt     = NW'(iss_r + NW'(1));
      if (iss_nxt == cnt_r) begin
        busy_nxt = 1'b0;
      end
    end

    if (chk_vld_r) begin
      if (!visited[chk_idx_r] && (!found_r || rd_data < bd_r)) begin
        found_nxt = 1'b1;
        best_nxt  = chk_idx_r;
        bd_nxt    = rd_data;
      end
      if (32'(chk_idx_r) == 32'(cnt_r) - 32'd1) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      chk_vld_r <= 1'b0;
      done_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      chk_vld_r <= chk_vld_nxt;
      done_r    <= done_nxt;
      found_r   <= found_nxt;
    end
    iss_r     <= iss_nxt;
    cnt_r     <= cnt_nxt;
    row_r     <= row_nxt;
    chk_idx_r <= chk_idx_nxt;
    best_r    <= best_nxt;
    bd_r      <= bd_nxt;
  end

  assign res.done  = done_r;
  assign res.best  = nnt_pkg::CITY_W_MAX'(best_r);
  assign best_dist = bd_r;

endmodule

@@ src/tsp_nearest_neighbor_tour.sv @@
// tsp_nearest_neighbor_tour: top level, matrix load, tour sequencer and result register
// depends on nnt_pkg, nnt_ram and nnt_scan
//
//   channel | ports                                               | direction
//   in      | in_valid in_stall in_from_city in_to_city           | load entry
//           | in_distance in_start_solve                          |
//   out     | out_valid out_stall out_tour_position out_city      | tour result
//           | out_tour_length out_last                            |
//   cfg     | cfg_wr_en cfg_wr_data                               | city_count write
//
// matrix entries load one per cycle into the distance ram while idle
// after the entry with start_solve, each tour step reads one matrix row through the
// single ram read port; the return leg then reads the last city's distance to city 0
// in_stall stays high from the start transaction until the last result is taken
// a stalled result holds in the output register; the step search overlaps it
// reset is synchronous; the ram content is not cleared and needs no clearing pass
module tsp_nearest_neighbor_tour #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int DIST_WIDTH = nnt_pkg::DIST_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [nnt_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nnt_pkg::CITY_W-1:0]  in_from_city,
  input  logic [nnt_pkg::CITY_W-1:0]  in_to_city,
  input  logic [nnt_pkg::DIN_W-1:0]   in_distance,
  input  logic                        in_start_solve,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nnt_pkg::CITY_W-1:0]  out_tour_position,
  output logic [nnt_pkg::CITY_W-1:0]  out_city,
  output logic [nnt_pkg::LEN_W-1:0]   out_tour_length,
  output logic                        out_last
);

  localparam int N_LIM = (MAX_CITIES < nnt_pkg::RESULT_CAP) ? MAX_CITIES
                                                              : nnt_pkg::RESULT_CAP;
  localparam int NW    = $clog2(N_LIM + 1);
  localparam int IW    = $clog2(MAX_CITIES);
  localparam int AW    = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int LW    = nnt_pkg::LEN_W;
  localparam int SW    = ((DIST_WIDTH > LW) ? DIST_WIDTH : LW) + 1;

  nnt_pkg::state_t state_r, state_nxt;

  logic [nnt_pkg::CFG_W-1:0] city_count_r;
  logic [NW-1:0]             n_r, n_nxt, n_clamp;
  logic [NW-1:0]             pos_r, pos_nxt;
  logic [IW-1:0]             cur_r, cur_nxt;
  logic [LW-1:0]             len_r, len_nxt;
  logic [MAX_CITIES-1:0]     visited_r, visited_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [NW-1:0]             out_pos_r, out_pos_nxt;
  logic [IW-1:0]             out_city_r, out_city_nxt;
  logic [LW-1:0]             out_len_r, out_len_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_free;

  logic                      in_acc;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [DIST_WIDTH-1:0]     rd_data;

  nnt_pkg::scan_req_t        scan_req;
  nnt_pkg::scan_res_t        scan_res;
  logic                      scan_rd_en;
  logic [AW-1:0]             scan_rd_addr;
  logic [DIST_WIDTH-1:0]     scan_best_dist;

  logic [DIST_WIDTH-1:0]     add_d;
  logic [SW-1:0]             len_sum;
  logic [LW-1:0]             len_sat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= nnt_pkg::MIN_CITIES;
    end else if (cfg_wr_en) begin
      city_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (city_count_r < nnt_pkg::MIN_CITIES) begin
      n_clamp = NW'(2);
    end else if (32'(city_count_r) > N_LIM) begin
      n_clamp = NW'(N_LIM);
    end else begin
      n_clamp = NW'(city_count_r);
    end
  end

  // matrix load
  assign in_stall = (state_r != nnt_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (32'(in_from_city) < MAX_CITIES)
                           && (32'(in_to_city) < MAX_CITIES);
  assign wr_addr  = AW'(32'(in_from_city) * 32'(MAX_CITIES) + 32'(in_to_city));

  assign rd_en   = scan_rd_en || (state_r == nnt_pkg::ST_RET_RD);
  assign rd_addr = (state_r == nnt_pkg::ST_RET_RD)
                   ? AW'(32'(cur_r) * 32'(MAX_CITIES)) : scan_rd_addr;

  nnt_ram #(
    .WIDTH (DIST_WIDTH),
    .DEPTH (MAX_CITIES * MAX_CITIES)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (DIST_WIDTH'(in_distance)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nnt_scan #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (scan_req),
    .visited   (visited_r),
    .rd_data   (rd_data),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_rd_addr),
    .res       (scan_res),
    .best_dist (scan_best_dist)
  );

  // saturating length add, shared by the step update and the return leg
  assign add_d   = (state_r == nnt_pkg::ST_RET_WAIT) ? rd_data : scan_best_dist;
  assign len_sum = SW'(len_r) + SW'(add_d);
  assign len_sat = (len_sum > SW'(nnt_pkg::LEN_MAX)) ? nnt_pkg::LEN_MAX : LW'(len_sum);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    visited_nxt   = visited_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_city_nxt  = out_city_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    scan_req.start = 1'b0;
    scan_req.row   = nnt_pkg::CITY_W_MAX'(cur_r);
    scan_req.count = nnt_pkg::CNT_W_MAX'(n_r);

    case (state_r)
      nnt_pkg::ST_IDLE: begin
        if (in_acc && in_start_solve) begin
          n_nxt          = n_clamp;
          pos_nxt        = '0;
          cur_nxt        = '0;
          len_nxt        = '0;
          visited_nxt    = '0;
          visited_nxt[0] = 1'b1;
          state_nxt      = nnt_pkg::ST_PUSH;
        end
      end
      nnt_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = pos_r;
          out_city_nxt   = cur_r;
          out_len_nxt    = len_r;
          out_last_nxt   = 1'b0;
          scan_req.start = 1'b1;
          state_nxt      = nnt_pkg::ST_SCAN;
        end
      end
      nnt_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          visited_nxt[IW'(scan_res.best)] = 1'b1;
          cur_nxt = IW'(scan_res.best);
          len_nxt = len_sat;
          pos_nxt = NW'(pos_r + NW'(1));
          if (NW'(pos_r + NW'(1)) == NW'(n_r - NW'(1))) begin
            state_nxt = nnt_pkg::ST_RET_RD;
          end else begin
            state_nxt = nnt_pkg::ST_PUSH;
          end
        end
      end
      nnt_pkg::ST_RET_RD: begin
        state_nxt = nnt_pkg::ST_RET_WAIT;
      end
      nnt_pkg::ST_RET_WAIT: begin
        // ram output holds until the next read, so waiting here is safe
        if (out_free) begin
          len_nxt       = len_sat;
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_city_nxt  = cur_r;
          out_len_nxt   = len_sat;
          out_last_nxt  = 1'b1;
          state_nxt     = nnt_pkg::ST_DRAIN;
        end
      end
      nnt_pkg::ST_DRAIN: begin
        if (!out_stall) begin
          state_nxt = nnt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nnt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nnt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      visited_r   <= '0;
      cur_r       <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      n_r         <= NW'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      visited_r   <= visited_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      n_r         <= n_nxt;
    end
    out_pos_r  <= out_pos_nxt;
    out_city_r <= out_city_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_tour_position = nnt_pkg::CITY_W'(out_pos_r);
  assign out_city          = nnt_pkg::CITY_W'(out_city_r);
  assign out_tour_length   = out_len_r;
  assign out_last          = out_last_r;

endmodule
